>>> hdl/assert_macros.svh
// Assertion macros used by the checker of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low)
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hdl/rfsw_pkg.sv
// Shared constants, types and code-word builder for the RF switch code transmitter.
// No dependencies; imported by every module of the block.
package rfsw_pkg;

    // Frame geometry
    localparam int CODE_BITS      = 24;
    localparam int SYNC_LOW_UNITS = 31;
    localparam int CODE_W         = 24;
    localparam int SYNC_UNITS     = 1 + SYNC_LOW_UNITS;
    localparam int DATA_UNITS     = 4;
    localparam int ONE_HIGH_UNITS = 3;
    localparam int SYM_MAX        = (SYNC_UNITS > DATA_UNITS) ? SYNC_UNITS : DATA_UNITS;
    localparam int UC_W           = $clog2(SYM_MAX);
    localparam int BP_W           = $clog2(CODE_BITS + 1);
    localparam int IDX_W          = $clog2(CODE_BITS);

    // Counter and register widths
    localparam int TICK_W = 16;
    localparam int REP_W  = 8;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 1;

    // Stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Configuration register indexes and reset values
    localparam logic [ADDR_W-1:0] REG_UNIT_TICKS   = 1'd0;
    localparam logic [ADDR_W-1:0] REG_REPEAT_COUNT = 1'd1;
    localparam logic [TICK_W-1:0] UNIT_TICKS_RST   = 16'd350;
    localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 8'd10;

    // Item kinds carried on tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEND = 1'b1;

    // Group and socket selector codes
    localparam logic [2:0] GROUP_A  = 3'd0;
    localparam logic [2:0] GROUP_B  = 3'd1;
    localparam logic [2:0] GROUP_C  = 3'd2;
    localparam logic [2:0] GROUP_D  = 3'd3;
    localparam logic [2:0] SOCKET_1 = 3'd1;
    localparam logic [2:0] SOCKET_2 = 3'd2;
    localparam logic [2:0] SOCKET_3 = 3'd3;

    // Code word bytes and masks
    localparam logic [7:0] CODE_BASE = 8'h55;
    localparam logic [7:0] LAST_OFF  = 8'h54;
    localparam logic [7:0] LAST_ON   = 8'h57;
    localparam logic [7:0] MASK_1    = 8'h15;
    localparam logic [7:0] MASK_2    = 8'h45;
    localparam logic [7:0] MASK_3    = 8'h51;
    localparam logic [7:0] MASK_4    = 8'h54;

    typedef struct packed {
        logic       func;
        logic [2:0] group_sel;
        logic [2:0] socket_sel;
        logic       switch_on;
    } rfsw_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] unit_ticks;
        logic [REP_W-1:0]  repeat_count;
    } rfsw_cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
    } rfsw_result_t;

    // Build the 24-bit code word from group, socket and on/off
    function automatic logic [CODE_W-1:0] build_code(input logic [2:0] grp,
                                                    input logic [2:0] sock,
                                                    input logic       on);
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] low;
        top = CODE_BASE;
        mid = CODE_BASE;
        low = on ? LAST_ON : LAST_OFF;
        case (grp)
            GROUP_A: top = top & MASK_1;
            GROUP_B: top = top & MASK_2;
            GROUP_C: top = top & MASK_3;
            GROUP_D: top = top & MASK_4;
            default: top = top;
        endcase
        case (sock)
            SOCKET_1: mid = mid & MASK_1;
            SOCKET_2: mid = mid & MASK_2;
            SOCKET_3: mid = mid & MASK_3;
            default:  mid = mid;
        endcase
        return {top, mid, low};
    endfunction

endpackage

>>> hdl/rf_switch_code_transmitter_core.sv
// Top level of the RF switch code transmitter: configuration registers,
// encoder and result register. Depends on rfsw_pkg, rfsw_encoder, rfsw_out_stage.

// The block takes one transaction per clock cycle and returns exactly one result
// transaction for each, in the cycle after acceptance; s_axis_tready drops only while
// the result register is full and the downstream side stalls. A tick transaction
// (tuser 0) reports the line level for that tick and advances the symbol counters;
// a send transaction (tuser 1) loads a new code when idle and is ignored while busy.
// One command occupies repeat_count * (32 + 4 * 24) * unit_ticks ticks at the
// default geometry, i.e. repeat_count * (1 + SYNC_LOW_UNITS + 4 * CODE_BITS) units.
// Write unit_ticks and repeat_count only while no transmission is in progress;
// zero values act as one.
module rf_switch_code_transmitter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [rfsw_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [rfsw_pkg::CFG_W-1:0]       cfg_wdata,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] group_sel, [5:3] socket_sel, [6] switch_on, [7] zero
    input  logic [rfsw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  logic                             s_axis_tuser,
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] line_level, [1] busy_res, [7:2] zero
    output logic [rfsw_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import rfsw_pkg::*;

    logic [TICK_W-1:0] unit_ticks_reg;
    logic [REP_W-1:0]  repeat_count_reg;
    rfsw_cfg_t         cfg;
    rfsw_item_t        item;
    rfsw_result_t      result;
    logic              item_accept;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg   <= UNIT_TICKS_RST;
            repeat_count_reg <= REPEAT_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_UNIT_TICKS:   unit_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                REG_REPEAT_COUNT: repeat_count_reg <= cfg_wdata[REP_W-1:0];
                default:          unit_ticks_reg   <= unit_ticks_reg;
            endcase
        end
    end

    assign cfg.unit_ticks   = unit_ticks_reg;
    assign cfg.repeat_count = repeat_count_reg;

    // Unpack the input transaction
    assign item.func       = s_axis_tuser;
    assign item.group_sel  = s_axis_tdata[2:0];
    assign item.socket_sel = s_axis_tdata[5:3];
    assign item.switch_on  = s_axis_tdata[6];

    assign item_accept = s_axis_tvalid && s_axis_tready;

    rfsw_encoder u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_accept),
        .item       (item),
        .cfg        (cfg),
        .result     (result)
    );

    rfsw_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_result     (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> hdl/rfsw_encoder.sv
// Symbol timing counters and code register of the OOK encoder.
// Depends on rfsw_pkg; updates its state once per accepted transaction.
module rfsw_encoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  rfsw_pkg::rfsw_item_t  item,
    input  rfsw_pkg::rfsw_cfg_t   cfg,
    output rfsw_pkg::rfsw_result_t result
);
    import rfsw_pkg::*;

    logic [CODE_BITS-1:0] code_reg,    code_next;
    logic [BP_W-1:0]      bit_pos_reg, bit_pos_next;
    logic [UC_W-1:0]      unit_reg,    unit_next;
    logic [TICK_W-1:0]    tick_reg,    tick_next;
    logic [REP_W-1:0]     rep_reg,     rep_next;
    logic                 active_reg,  active_next;

    logic [31:0]          code_ext;
    logic [TICK_W-1:0]    unit_ticks_eff;
    logic [TICK_W:0]      tick_inc;
    logic [UC_W:0]        unit_inc;
    logic [UC_W:0]        sym_units;
    logic [BP_W:0]        bit_pos_inc;

    // Level of the line for a given state
    function automatic logic level_of(input logic                 act,
                                      input logic [BP_W-1:0]      bp,
                                      input logic [UC_W-1:0]      uc,
                                      input logic [CODE_BITS-1:0] code);
        logic [BP_W-1:0]  idx_full;
        logic [IDX_W-1:0] idx;
        logic             lvl;
        idx_full = BP_W'(CODE_BITS) - bp;
        idx      = idx_full[IDX_W-1:0];
        if (!act) begin
            lvl = 1'b0;
        end else if (bp == '0) begin
            lvl = (uc == '0);
        end else if (code[idx]) begin
            lvl = (uc < UC_W'(ONE_HIGH_UNITS));
        end else begin
            lvl = (uc == '0);
        end
        return lvl;
    endfunction

    // Zero-extend the built word, keep the low CODE_BITS bits
    assign code_ext = 32'(build_code(item.group_sel, item.socket_sel, item.switch_on));

    // Clamp zero unit length to one tick
    assign unit_ticks_eff = (cfg.unit_ticks == '0) ? TICK_W'(1) : cfg.unit_ticks;
    assign tick_inc       = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign unit_inc       = {1'b0, unit_reg} + (UC_W+1)'(1);
    assign sym_units      = (bit_pos_reg == '0) ? (UC_W+1)'(SYNC_UNITS)
                                                : (UC_W+1)'(DATA_UNITS);
    assign bit_pos_inc    = {1'b0, bit_pos_reg} + (BP_W+1)'(1);

    // Load on a send command, advance counters on a tick
    always_comb begin
        code_next    = code_reg;
        bit_pos_next = bit_pos_reg;
        unit_next    = unit_reg;
        tick_next    = tick_reg;
        rep_next     = rep_reg;
        active_next  = active_reg;
        result.line_level = level_of(active_reg, bit_pos_reg, unit_reg, code_reg);

        if (item_valid) begin
            if (item.func == FUNC_SEND) begin
                if (!active_reg) begin
                    code_next    = code_ext[CODE_BITS-1:0];
                    bit_pos_next = '0;
                    unit_next    = '0;
                    tick_next    = '0;
                    rep_next     = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;
                    active_next  = 1'b1;
                end
                result.line_level = level_of(active_next, bit_pos_next, unit_next, code_next);
            end else if (active_reg) begin
                if (tick_inc < {1'b0, unit_ticks_eff}) begin
                    tick_next = tick_inc[TICK_W-1:0];
                end else begin
                    tick_next = '0;
                    if (unit_inc < sym_units) begin
                        unit_next = unit_inc[UC_W-1:0];
                    end else begin
                        unit_next = '0;
                        if (bit_pos_inc <= (BP_W+1)'(CODE_BITS)) begin
                            bit_pos_next = bit_pos_inc[BP_W-1:0];
                        end else begin
                            bit_pos_next = '0;
                            rep_next     = (rep_reg != '0) ? rep_reg - REP_W'(1) : rep_reg;
                            active_next  = (rep_next != '0);
                        end
                    end
                end
            end
        end
        result.busy_res = active_next;
    end

    // Hold state between transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg <= '0;
            unit_reg    <= '0;
            tick_reg    <= '0;
            rep_reg     <= '0;
            active_reg  <= 1'b0;
        end else begin
            bit_pos_reg <= bit_pos_next;
            unit_reg    <= unit_next;
            tick_reg    <= tick_next;
            rep_reg     <= rep_next;
            active_reg  <= active_next;
        end
    end

    // Code word needs no reset: it is read only while active
    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

endmodule

>>> hdl/rfsw_out_stage.sv
// Result register of the OOK encoder with stream handshake on the master side.
// Depends on rfsw_pkg for the result type and payload width.
module rfsw_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rfsw_pkg::rfsw_result_t           in_result,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rfsw_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import rfsw_pkg::*;

    logic         valid_reg, valid_next;
    rfsw_result_t data_reg,  data_next;

    // Take a new result when empty or when the held one leaves this cycle
    assign in_ready = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            data_next  = in_result;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-2)'(0), data_reg.busy_res, data_reg.line_level};

endmodule

>>> hdl/rfsw_checker.sv
// Port-level checker for rf_switch_code_transmitter_core, attached by bind.
// Depends on rfsw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfsw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rfsw_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rfsw_pkg::*;

    // Stalled result transaction holds its payload
    `ASSERT_CLK(a_hold_stalled, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // Every accepted transaction shows a result in the next cycle
    `ASSERT_CLK(a_result_follows, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "no result after accepted transaction")

    // A send command always leaves the block busy
    `ASSERT_CLK(a_send_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_SEND) |=> m_axis_tdata[1], "send command did not report busy")

    // Line is low whenever the block reports not busy
    `ASSERT_CLK(a_idle_low, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0], "line high while not busy")

endmodule

bind rf_switch_code_transmitter_core rfsw_checker u_rfsw_checker (.*);
